>>> design/b32e_pkg.sv
// b32e_pkg: shared types, constants and the character map for the base32
// stream encoder. No dependencies.
package b32e_pkg;

  localparam int unsigned GroupBits      = 5;
  localparam int unsigned DefQueueDepth  = 2;

  localparam logic [6:0] CharPad   = 7'd61;  // '='
  localparam logic [6:0] CharUpA   = 7'd65;  // 'A'
  localparam logic [6:0] CharDig2  = 7'd50;  // '2'
  localparam logic [4:0] AlphaSplit = 5'd26;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_item_t;

  // one accepted byte after classification: up to three symbols, pad count
  typedef struct packed {
    logic [2:0][4:0] sym;
    logic [1:0]      n_sym;
    logic [2:0]      n_pad;
    logic            last;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [6:0] sym_to_ascii(input logic [4:0] v);
    logic [6:0] r;
    if (v < AlphaSplit) begin
      r = CharUpA + {2'b00, v};
    end else begin
      r = CharDig2 + {2'b00, v - AlphaSplit};
    end
    return r;
  endfunction

endpackage

>>> design/b32e_front.sv
// b32e_front: accepts message bytes, holds leftover bits and character phase,
// splits each byte into symbols and pad count. Depends on b32e_pkg.
module b32e_front
  import b32e_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output desc_t    push_desc
);

  logic [3:0]  left_bits_r, left_bits_nxt;
  logic [2:0]  left_cnt_r, left_cnt_nxt;
  logic [2:0]  phase_r, phase_nxt;

  logic [11:0] acc;
  logic [3:0]  total;
  logic [3:0]  sh0;
  logic [3:0]  sh1;
  logic        two;
  logic [2:0]  rem;
  logic [11:0] mask;
  logic [3:0]  rem_bits;
  logic [8:0]  flush_wide;
  logic        flush;
  logic [1:0]  n_sym;
  logic [2:0]  phase_after;
  logic [11:0] d0_wide;
  logic [11:0] d1_wide;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    acc         = {left_bits_r, in_data.byte_value};
    total       = {1'b0, left_cnt_r} + 4'd8;
    two         = (total >= 4'd10);
    sh0         = total - 4'(GroupBits);
    sh1         = total - 4'd10;
    d0_wide     = acc >> sh0;
    d1_wide     = acc >> sh1;
    rem         = two ? sh1[2:0] : sh0[2:0];
    mask        = (12'd1 << rem) - 12'd1;
    rem_bits    = 4'(acc & mask);
    flush_wide  = {5'd0, rem_bits} << (3'd5 - rem);
    flush       = in_data.last_byte && (rem != 3'd0);
    n_sym       = (two ? 2'd2 : 2'd1) + {1'b0, flush};
    phase_after = phase_r + {1'b0, n_sym};

    push_desc.sym[0] = d0_wide[4:0];
    push_desc.sym[1] = two ? d1_wide[4:0] : flush_wide[4:0];
    push_desc.sym[2] = flush_wide[4:0];
    push_desc.n_sym  = n_sym;
    push_desc.n_pad  = in_data.last_byte ? (3'd0 - phase_after) : 3'd0;
    push_desc.last   = in_data.last_byte;

    left_bits_nxt = left_bits_r;
    left_cnt_nxt  = left_cnt_r;
    phase_nxt     = phase_r;
    if (push) begin
      if (in_data.last_byte) begin
        left_bits_nxt = 4'd0;
        left_cnt_nxt  = 3'd0;
        phase_nxt     = 3'd0;
      end else begin
        left_bits_nxt = rem_bits;
        left_cnt_nxt  = rem;
        phase_nxt     = phase_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= 4'd0;
      left_cnt_r  <= 3'd0;
      phase_r     <= 3'd0;
    end else begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
      phase_r     <= phase_nxt;
    end
  end

endmodule

>>> design/b32e_queue.sv
// b32e_queue: small descriptor fifo between front and back.
// Depends on b32e_pkg.
module b32e_queue
  import b32e_pkg::*;
#(
  parameter int unsigned DEPTH = DefQueueDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  desc_t                        push_desc,
  input  logic                         pop,
  output desc_t                        head,
  output q_stat_t                      q_stat,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned LvlW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [LvlW-1:0] FullLvl = LvlW'(DEPTH);

  desc_t           slot_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LvlW-1:0] level_r, level_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (level_r == FullLvl);
  assign q_stat.empty = (level_r == '0);
  assign level        = level_r;
  assign head         = slot_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LvlW'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LvlW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

>>> design/b32e_back.sv
// b32e_back: steps through one descriptor a character per cycle when not
// stalled and holds the result in an output register. Depends on b32e_pkg.
module b32e_back
  import b32e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  desc_t     head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic [3:0] n_total;
  logic [3:0] last_idx;
  logic       at_end;
  logic       advance;
  logic [4:0] cur_sym;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    n_total  = {2'b00, head.n_sym} + {1'b0, head.n_pad};
    last_idx = n_total - 4'd1;
    at_end   = (idx_r == last_idx);
    advance  = !q_stat.empty && (!out_valid_r || out_ready);
    pop      = advance && at_end;

    case (idx_r[1:0])
      2'd0:    cur_sym = head.sym[0];
      2'd1:    cur_sym = head.sym[1];
      default: cur_sym = head.sym[2];
    endcase

    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_char  = (idx_r < {2'b00, head.n_sym}) ? sym_to_ascii(cur_sym)
                                                             : CharPad;
      out_data_nxt.last_char = head.last && at_end;
      idx_nxt                = at_end ? 4'd0 : idx_r + 4'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/base32_stream_encoder_core.sv
// base32_stream_encoder_core: top level of the base32 stream encoder.
// Depends on b32e_pkg, b32e_front, b32e_queue, b32e_back.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data    | one message byte, last flag
//   output  | out_valid, out_ready, out_data | one ascii character, last flag
//
// a byte is taken in any cycle with queue space; it yields one to three
// characters plus '=' pads on the last byte, sent by the back sequencer one word
// per cycle while the output is not stalled. the first character passes through
// a queue slot and the output register before it is valid.
// synchronous active-low reset clears all control state; no clearing pass.
// either side may stall; the queue and output register decouple them.
module base32_stream_encoder_core
  import b32e_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1);

  logic            push;
  desc_t           push_desc;
  desc_t           head;
  logic            pop;
  q_stat_t         q_stat;
  logic [LvlW-1:0] q_level;

  b32e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat),
    .level     (q_level)
  );

  b32e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= LvlW'(QUEUE_DEPTH))
    else $error("queue level above depth");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.out_char >= 7'd65 && out_data.out_char <= 7'd90) ||
                   (out_data.out_char >= 7'd50 && out_data.out_char <= 7'd55) ||
                   out_data.out_char == CharPad))
    else $error("character outside base32 set");

  a_pad_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.out_char == CharPad && !out_data.last_char)
      |=> !out_valid || out_data.out_char == CharPad)
    else $error("data character after padding");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

>>> tb/sv/base32_stream_encoder_core_chk.sv
// base32_stream_encoder_core_chk: watches both channels of the base32 stream encoder,
// predicts the characters of every accepted byte and compares each output word.
// Depends on b32e_pkg.
module base32_stream_encoder_core_chk
  import b32e_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  in_item_t        in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  out_item_t       out_data,
  output int unsigned     fail_count,
  output int unsigned     chars_pending,
  output int unsigned     bytes_seen,
  output int unsigned     chars_seen,
  output int unsigned     msgs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*32-1:0] Alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  out_item_t   char_q[$];
  logic [3:0]  rem_bits;
  logic [2:0]  rem_cnt;
  logic [2:0]  char_phase;

  initial begin
    fail_count    = 0;
    chars_pending = 0;
    bytes_seen    = 0;
    chars_seen    = 0;
    msgs_seen     = 0;
    rem_bits      = '0;
    rem_cnt       = '0;
    char_phase    = '0;
  end

  function automatic logic [6:0] b32_char(input logic [4:0] grp);
    logic [7:0] code;
    code = Alphabet[8*(31 - grp) +: 8];
    return code[6:0];
  endfunction

  task automatic push_char(input logic [6:0] ch);
    out_item_t w;
    w.out_char  = ch;
    w.last_char = 1'b0;
    char_q = {char_q, w};
    char_phase = char_phase + 3'd1;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [11:0] acc;
    int unsigned nbits;
    out_item_t   w;
    acc   = {rem_bits, b};
    nbits = rem_cnt + 8;
    while (nbits >= GroupBits) begin
      nbits = nbits - GroupBits;
      push_char(b32_char(5'(acc >> nbits)));
    end
    acc = acc & ((12'd1 << nbits) - 12'd1);
    if (!fin) begin
      rem_bits = acc[3:0];
      rem_cnt  = 3'(nbits);
    end else begin
      if (nbits > 0) begin
        push_char(b32_char(5'(acc << (GroupBits - nbits))));
      end
      while (char_phase != 3'd0) begin
        push_char(CharPad);
      end
      w = char_q[$];
      w.last_char = 1'b1;
      char_q[$] = w;
      rem_bits = '0;
      rem_cnt  = '0;
      msgs_seen = msgs_seen + 1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        chars_seen = chars_seen + 1;
        if (char_q.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: unexpected word, expected none, got char %0d last %0b",
                   $time, out_data.out_char, out_data.last_char);
        end else begin
          want = char_q.pop_front();
          if (out_data.out_char !== want.out_char) begin
            fail_count = fail_count + 1;
            $display("%0t: out_char expected %0d got %0d",
                     $time, want.out_char, out_data.out_char);
          end
          if (out_data.last_char !== want.last_char) begin
            fail_count = fail_count + 1;
            $display("%0t: last_char expected %0b got %0b",
                     $time, want.last_char, out_data.last_char);
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_seen = bytes_seen + 1;
        encode_byte(in_data.byte_value, in_data.last_byte);
      end
      chars_pending = char_q.size();
    end
  end

endmodule

>>> tb/sv/base32_stream_encoder_core_tb.sv
// base32_stream_encoder_core_tb: drives fixed messages, then ones of random length
// and content, into the encoder with random gaps and stalls and reports the verdict.
// Depends on b32e_pkg, base32_stream_encoder_core and base32_stream_encoder_core_chk.
module base32_stream_encoder_core_tb
  import b32e_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 260;
  localparam int unsigned CycleLimit  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int unsigned fail_count;
  int unsigned chars_pending;
  int unsigned bytes_seen;
  int unsigned chars_seen;
  int unsigned msgs_seen;

  logic [7:0]  msg_q[$];
  bit          send_burst;
  bit          steady_ready;
  int unsigned stall_left;
  int unsigned ready_cycles;
  int unsigned cycle_cnt;

  always #5 clk = ~clk;

  base32_stream_encoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  base32_stream_encoder_core_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .bytes_seen    (bytes_seen),
    .chars_seen    (chars_seen),
    .msgs_seen     (msgs_seen)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = send_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_value: b, last_byte: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_msg();
    send_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
    end
  endtask

  always @(posedge clk) begin
    ready_cycles = ready_cycles + 1;
    if (ready_cycles % 256 == 0) begin
      steady_ready = ($urandom_range(0, 2) == 0);
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!steady_ready && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("base32_stream_encoder_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned rand_bytes;
    int unsigned len;
    int unsigned r;
    in_valid     = 1'b0;
    in_data      = '0;
    send_burst   = 1'b0;
    steady_ready = 1'b0;
    stall_left   = 0;
    ready_cycles = 0;
    cycle_cnt    = 0;
    rand_bytes   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    msg_q = '{8'hFF};
    send_msg();
    msg_q = '{8'h00, 8'h00};
    send_msg();
    msg_q = '{8'hAA, 8'h55, 8'h80};
    send_msg();
    msg_q = '{8'h01, 8'h7F, 8'hFE, 8'h10};
    send_msg();
    msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_msg();
    msg_q = '{8'h00, 8'h44, 8'h32, 8'h14, 8'hC7};
    send_msg();
    msg_q = '{8'h0F, 8'hF0, 8'h3C, 8'hC3};
    send_msg();

    while (rand_bytes < RandomBytes) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(1, 8);
      end else if (r < 9) begin
        len = $urandom_range(9, 20);
      end else begin
        len = $urandom_range(21, 40);
      end
      msg_q.delete();
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          msg_q = {msg_q, 8'h00};
        end else if (r == 1) begin
          msg_q = {msg_q, 8'hFF};
        end else begin
          msg_q = {msg_q, 8'($urandom())};
        end
      end
      send_msg();
      rand_bytes = rand_bytes + len;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d bytes in %0d messages, %0d characters compared",
             bytes_seen, msgs_seen, chars_seen);
    if (fail_count == 0) begin
      $display("base32_stream_encoder_core: match");
    end else begin
      $display("base32_stream_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
